>>> rtl/core/tac_pkg.sv
// Shared constants, codes and structures of the task admission controller.
// No dependencies; imported by every module of the block.
package tac_pkg;

   // Sizing of the block
   localparam int NUM_RESOURCES  = 16;   // 1 .. 16 in this port layout
   localparam int NUM_CAP_GROUPS = 4;    // 1 .. 4
   localparam int NUM_PAR_GROUPS = 8;    // 1 .. 15 with a 4-bit group field

   // Field widths
   localparam int RES_W  = 16;
   localparam int DL_W   = 48;
   localparam int TIME_W = 63;
   localparam int CNT_W  = 8;
   localparam int CG_W   = 2;
   localparam int PG_W   = 4;

   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 48;
   localparam int REQ_TDATA_W = 208;
   localparam int RSP_TDATA_W = 96;

   localparam logic [CNT_W-1:0] CNT_MAX = '1;

   // Resource bits beyond NUM_RESOURCES are ignored
   localparam logic [RES_W-1:0] RES_MASK = (NUM_RESOURCES >= RES_W) ? '1 :
                                           RES_W'((32'd1 << NUM_RESOURCES) - 32'd1);

   typedef enum logic {
      REQ_ADMIT    = 1'b0,
      REQ_COMPLETE = 1'b1
   } req_kind_type;

   typedef enum logic [1:0] {
      ST_READY   = 2'd0,
      ST_BLOCKED = 2'd1,
      ST_STALE   = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      RSN_OK        = 4'd0,
      RSN_DEPS      = 4'd1,
      RSN_PORTS     = 4'd2,
      RSN_LOCKED    = 4'd3,
      RSN_MAXPAR    = 4'd4,
      RSN_CAPACITY  = 4'd5,
      RSN_EXCLUSIVE = 4'd6,
      RSN_PARGROUP  = 4'd7,
      RSN_DEADLINE  = 4'd8
   } reason_type;

   typedef enum logic [1:0] {
      DL_NONE   = 2'd0,
      DL_WITHIN = 2'd1,
      DL_MISSED = 2'd2
   } dl_state_type;

   // Register indexes; group limits follow CSR_GROUP_LIMIT_0 consecutively
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MAX_PARALLEL     = 3'd0,
      CSR_DEFAULT_DEADLINE = 3'd1,
      CSR_STALE_ON_MISS    = 3'd2,
      CSR_GROUP_LIMIT_0    = 3'd3
   } csr_index_type;

   typedef struct packed {
      req_kind_type       kind;
      logic               deps_ready;
      logic               ports_ready;
      logic [CG_W-1:0]    cap_group;
      logic [PG_W-1:0]    parallel_group;
      logic               par_allowed;
      logic               exclusive_lock;
      logic [RES_W-1:0]   resource_mask;
      logic [DL_W-1:0]    node_deadline_ns;
      logic [TIME_W-1:0]  evt_time_ns;
      logic [TIME_W-1:0]  sched_time_ns;
      logic               was_accepted;
   } request_type;

   typedef struct packed {
      logic [CNT_W-1:0]                     max_parallel;
      logic [DL_W-1:0]                      default_deadline_ns;
      logic                                 stale_on_miss;
      logic [NUM_CAP_GROUPS-1:0][CNT_W-1:0] group_limit;
   } cfg_type;

   typedef struct packed {
      logic [CNT_W-1:0]                     active_count;
      logic [RES_W-1:0]                     lock_held;
      logic [RES_W-1:0]                     lock_is_exclusive;
      logic [NUM_PAR_GROUPS-1:0]            par_group_active;
      logic [NUM_CAP_GROUPS-1:0][CNT_W-1:0] group_active_count;
   } state_type;

   typedef struct packed {
      logic              accepted;
      status_type        status_code;
      reason_type        reason_code;
      logic [RES_W-1:0]  blocked_resources;
      dl_state_type      deadline_state;
      logic [TIME_W-1:0] late_ns;
      logic [CNT_W-1:0]  active_tasks;
   } result_type;

endpackage

>>> rtl/core/tac_decide.sv
// Admission decision and state update for one transaction, purely combinational.
// Depends on tac_pkg.
module tac_decide import tac_pkg::*; (
   input  request_type req,
   input  cfg_type     cfg,
   input  state_type   st,
   output result_type  res,
   output state_type   st_nxt
);

   logic [RES_W-1:0]          mask;
   logic                      cg_valid;
   logic                      pg_valid;
   logic [NUM_PAR_GROUPS-1:0] pg_bit;
   logic [CNT_W-1:0]          lim;
   logic [CNT_W-1:0]          gcnt;
   logic [DL_W-1:0]           dl;
   logic [TIME_W-1:0]         late;
   logic                      missed;
   logic [RES_W-1:0]          blocked;
   logic                      admit_ok;

   always_comb begin
      mask     = req.resource_mask & RES_MASK;
      cg_valid = int'(req.cap_group) < NUM_CAP_GROUPS;
      pg_valid = (req.parallel_group != '0) && (int'(req.parallel_group) <= NUM_PAR_GROUPS);
      for (int p = 0; p < NUM_PAR_GROUPS; p++) begin
         pg_bit[p] = pg_valid && (int'(req.parallel_group) == p + 1);
      end
      lim  = '0;
      gcnt = '0;
      for (int g = 0; g < NUM_CAP_GROUPS; g++) begin
         if (cg_valid && int'(req.cap_group) == g) begin
            lim  = cfg.group_limit[g];
            gcnt = st.group_active_count[g];
         end
      end

      dl      = (req.node_deadline_ns != '0) ? req.node_deadline_ns : cfg.default_deadline_ns;
      late    = (req.evt_time_ns > req.sched_time_ns) ?
                (req.evt_time_ns - req.sched_time_ns) : '0;
      missed  = (dl != '0) && (late > TIME_W'(dl));
      blocked = st.lock_held & mask & (req.exclusive_lock ? '1 : st.lock_is_exclusive);
   end

   // Completion release, or the priority chain of the admit checks
   always_comb begin
      res          = '0;
      st_nxt       = st;
      admit_ok     = 1'b0;
      res.status_code = ST_BLOCKED;
      res.reason_code = RSN_OK;

      if (req.kind == REQ_COMPLETE) begin
         res.status_code = ST_READY;
         if (req.was_accepted) begin
            st_nxt.active_count = (st.active_count == '0) ? '0 :
                                  st.active_count - CNT_W'(1);
            st_nxt.par_group_active = st.par_group_active & ~pg_bit;
            for (int g = 0; g < NUM_CAP_GROUPS; g++) begin
               if (cg_valid && int'(req.cap_group) == g) begin
                  st_nxt.group_active_count[g] = (st.group_active_count[g] == '0) ? '0 :
                                                 st.group_active_count[g] - CNT_W'(1);
               end
            end
            st_nxt.lock_held         = st.lock_held & ~mask;
            st_nxt.lock_is_exclusive = st.lock_is_exclusive & ~mask;
         end
      end else begin
         res.blocked_resources = blocked;
         res.late_ns           = late;
         res.deadline_state    = missed ? DL_MISSED : ((dl != '0) ? DL_WITHIN : DL_NONE);

         if (!req.deps_ready) begin
            res.reason_code = RSN_DEPS;
         end else if (!req.ports_ready) begin
            res.reason_code = RSN_PORTS;
         end else if (blocked != '0) begin
            res.reason_code = RSN_LOCKED;
         end else if (cfg.max_parallel != '0 && st.active_count >= cfg.max_parallel) begin
            res.reason_code = RSN_MAXPAR;
         end else if (lim != '0 && gcnt >= lim) begin
            res.reason_code = RSN_CAPACITY;
         end else if (!req.par_allowed && st.active_count != '0) begin
            res.reason_code = RSN_EXCLUSIVE;
         end else if ((pg_bit & st.par_group_active) != '0 && !req.par_allowed) begin
            res.reason_code = RSN_PARGROUP;
         end else if (missed) begin
            res.reason_code = RSN_DEADLINE;
            res.status_code = cfg.stale_on_miss ? ST_STALE : ST_BLOCKED;
         end else begin
            admit_ok = 1'b1;
         end

         if (admit_ok) begin
            res.accepted    = 1'b1;
            res.status_code = ST_READY;
            st_nxt.active_count = (st.active_count == CNT_MAX) ? CNT_MAX :
                                  st.active_count + CNT_W'(1);
            st_nxt.par_group_active = st.par_group_active | pg_bit;
            for (int g = 0; g < NUM_CAP_GROUPS; g++) begin
               if (cg_valid && int'(req.cap_group) == g) begin
                  st_nxt.group_active_count[g] = (st.group_active_count[g] == CNT_MAX) ?
                                                 CNT_MAX : st.group_active_count[g] + CNT_W'(1);
               end
            end
            st_nxt.lock_held         = st.lock_held | mask;
            st_nxt.lock_is_exclusive = (st.lock_is_exclusive & ~mask) |
                                       (req.exclusive_lock ? mask : '0);
         end
      end

      res.active_tasks = st_nxt.active_count;
   end

endmodule

>>> rtl/core/task_admission_controller_unit.sv
// Top level of the task admission controller: stream ports, input and result
// registers, configuration and scheduler state. Depends on tac_pkg, tac_decide.
//
// Each request transaction is either an admit request or the completion of an
// earlier admission, and yields exactly one response transaction. A request is
// captured in the input register, decided in a single pass by tac_decide against
// the current locks and counters, and the response is written to the result
// register in the same edge that commits the new state. One transaction is
// taken per cycle except when the block stalls, as described below. The next
// request sees the state left by the previous one because the state commits
// together with the response. A waiting response does not block the input
// register from filling, so the block only stalls once both are occupied and
// the response side is holding back. Configuration writes are taken at any
// time (csr_ready is tied high) and are meant to land while the block is idle.
module task_admission_controller_unit import tac_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,

   // request channel
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // [0] deps_ready, [1] ports_ready, [3:2] cap_group, [7:4] parallel_group,
   // [8] par_allowed, [9] exclusive_lock, [25:10] resource_mask,
   // [73:26] node_deadline_ns, [136:74] evt_time_ns,
   // [199:137] sched_time_ns, [200] was_accepted, [207:201] zero
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // [0] req_type
   input  logic                   req_tuser,

   // response channel
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // [0] accepted, [2:1] status_code, [6:3] reason_code, [22:7] blocked_resources,
   // [24:23] deadline_state, [87:25] late_ns, [95:88] active_tasks
   output logic [RSP_TDATA_W-1:0] rsp_tdata,

   // configuration write channel
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   request_type req_ff, req_in;
   logic        req_vld_ff, req_vld_in;
   result_type  rsp_ff, rsp_in;
   logic        rsp_vld_ff, rsp_vld_in;
   state_type   st_ff, st_in;
   cfg_type     cfg_ff, cfg_in;

   result_type  dec_res;
   state_type   dec_st;
   logic        rsp_free;
   logic        advance;
   logic        req_take;

   tac_decide u_decide (
      .req    (req_ff),
      .cfg    (cfg_ff),
      .st     (st_ff),
      .res    (dec_res),
      .st_nxt (dec_st)
   );

   // Handshake: the result register frees when empty or being drained
   assign rsp_free   = !rsp_vld_ff || rsp_tready;
   assign advance    = req_vld_ff && rsp_free;
   assign req_tready = !req_vld_ff || advance;
   assign req_take   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   always_comb begin
      // input register capture
      req_in                   = req_ff;
      req_vld_in               = req_vld_ff ? !advance || req_take : req_take;
      if (req_take) begin
         req_in.kind              = req_kind_type'(req_tuser);
         req_in.deps_ready        = req_tdata[0];
         req_in.ports_ready       = req_tdata[1];
         req_in.cap_group         = req_tdata[3:2];
         req_in.parallel_group    = req_tdata[7:4];
         req_in.par_allowed       = req_tdata[8];
         req_in.exclusive_lock    = req_tdata[9];
         req_in.resource_mask     = req_tdata[25:10];
         req_in.node_deadline_ns  = req_tdata[73:26];
         req_in.evt_time_ns       = req_tdata[136:74];
         req_in.sched_time_ns     = req_tdata[199:137];
         req_in.was_accepted      = req_tdata[200];
      end

      // result register and state commit
      rsp_in     = rsp_ff;
      rsp_vld_in = rsp_vld_ff && !rsp_tready;
      st_in      = st_ff;
      if (advance) begin
         rsp_in     = dec_res;
         rsp_vld_in = 1'b1;
         st_in      = dec_st;
      end

      // configuration writes; indexes beyond the list are dropped
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_MAX_PARALLEL:     cfg_in.max_parallel        = csr_wdata[CNT_W-1:0];
            CSR_DEFAULT_DEADLINE: cfg_in.default_deadline_ns = csr_wdata[DL_W-1:0];
            CSR_STALE_ON_MISS:    cfg_in.stale_on_miss       = csr_wdata[0];
            default: begin
               for (int g = 0; g < NUM_CAP_GROUPS; g++) begin
                  if (int'(csr_index) == int'(CSR_GROUP_LIMIT_0) + g) begin
                     cfg_in.group_limit[g] = csr_wdata[CNT_W-1:0];
                  end
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
      if (reset) begin
         req_vld_ff                 <= 1'b0;
         rsp_vld_ff                 <= 1'b0;
         st_ff                      <= '0;
         cfg_ff.max_parallel        <= CNT_W'(1);
         cfg_ff.default_deadline_ns <= '0;
         cfg_ff.stale_on_miss       <= 1'b1;
         cfg_ff.group_limit         <= '0;
      end else begin
         req_vld_ff <= req_vld_in;
         rsp_vld_ff <= rsp_vld_in;
         st_ff      <= st_in;
         cfg_ff     <= cfg_in;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {rsp_ff.active_tasks, rsp_ff.late_ns, rsp_ff.deadline_state,
                        rsp_ff.blocked_resources, rsp_ff.reason_code, rsp_ff.status_code,
                        rsp_ff.accepted};

endmodule

>>> rtl/core/tac_checker.sv
// Port-level checks of the task admission controller, bound to the top level.
// Depends on tac_pkg and task_admission_controller_unit.
module tac_checker import tac_pkg::*; (
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata
);

   // response held while stalled
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   // an admitted task reports ready, no reason, no conflicts
   a_accept_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[0] |->
         rsp_tdata[2:1] == ST_READY && rsp_tdata[6:3] == RSN_OK && rsp_tdata[22:7] == '0)
      else $error("accepted response with reject fields");

   // stale only ever comes from a deadline miss
   a_stale_deadline: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[2:1] == ST_STALE |->
         rsp_tdata[6:3] == RSN_DEADLINE && rsp_tdata[24:23] == DL_MISSED)
      else $error("stale status without deadline miss");

   // a lock rejection names the conflicting resources
   a_locked_mask: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[6:3] == RSN_LOCKED |-> rsp_tdata[22:7] != '0)
      else $error("lock rejection with empty conflict mask");

endmodule

bind task_admission_controller_unit tac_checker u_tac_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

>>> tb/tac_tb_pkg.sv
`timescale 1ns / 1ps
// Response scoreboard for the task admission controller testbench.
// Depends on tac_pkg for field widths, codes and the request/result structures.
package tac_tb_pkg;
   import tac_pkg::*;

   class admission_scoreboard;
      // register copy
      logic [CNT_W-1:0]          par_limit;
      logic [DL_W-1:0]           dflt_deadline;
      logic                      stale_mode;
      logic [CNT_W-1:0]          grp_limit [NUM_CAP_GROUPS];
      // scheduler state copy
      logic [CNT_W-1:0]          active_cnt;
      logic [RES_W-1:0]          locks_held;
      logic [RES_W-1:0]          locks_excl;
      logic [NUM_PAR_GROUPS-1:0] pgroups_busy;
      logic [CNT_W-1:0]          grp_cnt [NUM_CAP_GROUPS];

      result_type                verdicts_due[$];
      request_type               running_tasks[$];   // admits the block took on
      int                        mismatches;
      int                        verdicts_seen;

      function new();
         par_limit     = 8'd1;
         dflt_deadline = '0;
         stale_mode    = 1'b1;
         active_cnt    = '0;
         locks_held    = '0;
         locks_excl    = '0;
         pgroups_busy  = '0;
         for (int g = 0; g < NUM_CAP_GROUPS; g++) begin
            grp_limit[g] = '0;
            grp_cnt[g]   = '0;
         end
         mismatches    = 0;
         verdicts_seen = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         int g;
         g = int'(idx) - int'(CSR_GROUP_LIMIT_0);
         case (idx)
            CSR_MAX_PARALLEL: begin
               par_limit = data[CNT_W-1:0];
            end
            CSR_DEFAULT_DEADLINE: begin
               dflt_deadline = data[DL_W-1:0];
            end
            CSR_STALE_ON_MISS: begin
               stale_mode = data[0];
            end
            default: begin
               // indexes past the last group limit are dropped
               if (g >= 0 && g < NUM_CAP_GROUPS) grp_limit[g] = data[CNT_W-1:0];
            end
         endcase
      endfunction

      function logic [CNT_W-1:0] count_up(logic [CNT_W-1:0] v);
         return (v == CNT_MAX) ? v : v + 1'b1;
      endfunction

      function logic [CNT_W-1:0] count_down(logic [CNT_W-1:0] v);
         return (v == '0) ? v : v - 1'b1;
      endfunction

      // Decide one request transaction against the state copy, queue the verdict
      function void note_request(request_type rq);
         logic [RES_W-1:0]          mask;
         logic [NUM_PAR_GROUPS-1:0] pg_bit;
         logic [DL_W-1:0]           deadline;
         logic [TIME_W-1:0]         late;
         logic [CNT_W-1:0]          glimit;
         logic [CNT_W-1:0]          gcount;
         logic                      cg_ok;
         logic                      missed;
         result_type                want;
         mask   = rq.resource_mask & RES_MASK;
         cg_ok  = (int'(rq.cap_group) < NUM_CAP_GROUPS);
         pg_bit = '0;
         if (rq.parallel_group != 0 && int'(rq.parallel_group) <= NUM_PAR_GROUPS)
            pg_bit[rq.parallel_group - 1] = 1'b1;
         want = '0;
         if (rq.kind == REQ_COMPLETE) begin
            if (rq.was_accepted) begin
               active_cnt   = count_down(active_cnt);
               pgroups_busy = pgroups_busy & ~pg_bit;
               if (cg_ok) grp_cnt[rq.cap_group] = count_down(grp_cnt[rq.cap_group]);
               // release drops the lock even if other shared holders remain
               locks_held = locks_held & ~mask;
               locks_excl = locks_excl & ~mask;
            end
         end else begin
            deadline = (rq.node_deadline_ns != '0) ? rq.node_deadline_ns : dflt_deadline;
            glimit   = cg_ok ? grp_limit[rq.cap_group] : '0;
            gcount   = cg_ok ? grp_cnt[rq.cap_group] : '0;
            late     = (rq.evt_time_ns > rq.sched_time_ns) ?
                       rq.evt_time_ns - rq.sched_time_ns : '0;
            missed   = (deadline != '0) && (late > TIME_W'(deadline));
            want.blocked_resources = locks_held & mask &
                                     (rq.exclusive_lock ? {RES_W{1'b1}} : locks_excl);
            want.late_ns = late;
            if (missed) want.deadline_state = DL_MISSED;
            else if (deadline != '0) want.deadline_state = DL_WITHIN;
            else want.deadline_state = DL_NONE;
            want.status_code = ST_BLOCKED;
            if (!rq.deps_ready) begin
               want.reason_code = RSN_DEPS;
            end else if (!rq.ports_ready) begin
               want.reason_code = RSN_PORTS;
            end else if (want.blocked_resources != '0) begin
               want.reason_code = RSN_LOCKED;
            end else if (par_limit != '0 && active_cnt >= par_limit) begin
               want.reason_code = RSN_MAXPAR;
            end else if (glimit != '0 && gcount >= glimit) begin
               want.reason_code = RSN_CAPACITY;
            end else if (!rq.par_allowed && active_cnt != '0) begin
               want.reason_code = RSN_EXCLUSIVE;
            end else if ((pgroups_busy & pg_bit) != '0 && !rq.par_allowed) begin
               want.reason_code = RSN_PARGROUP;
            end else if (missed) begin
               want.reason_code = RSN_DEADLINE;
               if (stale_mode) want.status_code = ST_STALE;
            end else begin
               want.accepted    = 1'b1;
               want.status_code = ST_READY;
               want.reason_code = RSN_OK;
               active_cnt   = count_up(active_cnt);
               pgroups_busy = pgroups_busy | pg_bit;
               if (cg_ok) grp_cnt[rq.cap_group] = count_up(grp_cnt[rq.cap_group]);
               locks_held = locks_held | mask;
               locks_excl = (locks_excl & ~mask) | (rq.exclusive_lock ? mask : '0);
               running_tasks.insert(running_tasks.size(), rq);
            end
         end
         want.active_tasks = active_cnt;
         verdicts_due.insert(verdicts_due.size(), want);
      endfunction

      function void compare_field(string what, logic [63:0] want, logic [63:0] seen);
         if (want !== seen) begin
            mismatches++;
            if (mismatches <= 10)
               $display("response %0d: %s expected %0h, got %0h", verdicts_seen, what, want,
                        seen);
         end
      endfunction

      function void check_verdict(result_type got);
         result_type want;
         verdicts_seen++;
         if (verdicts_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("response %0d arrived with no request outstanding", verdicts_seen);
            return;
         end
         want = verdicts_due.pop_front();
         compare_field("accepted", want.accepted, got.accepted);
         compare_field("status_code", want.status_code, got.status_code);
         compare_field("reason_code", want.reason_code, got.reason_code);
         compare_field("blocked_resources", want.blocked_resources, got.blocked_resources);
         compare_field("deadline_state", want.deadline_state, got.deadline_state);
         compare_field("late_ns", want.late_ns, got.late_ns);
         compare_field("active_tasks", want.active_tasks, got.active_tasks);
      endfunction

      function int pending();
         return verdicts_due.size();
      endfunction

      // verdicts never delivered count against the run as well
      function int failures();
         return mismatches + verdicts_due.size();
      endfunction
   endclass

endpackage

>>> tb/tb.sv
`timescale 1ns / 1ps
// Top-level testbench of task_admission_controller_unit: drives the stream and
// register ports and checks every response. Depends on tac_pkg and tac_tb_pkg.
module tb;
   import tac_pkg::*;
   import tac_tb_pkg::*;

   // Run ends as failed once this many cycles pass with no transaction anywhere
   localparam int STALL_LIMIT = 2000;
   // Register index outside the list: the write must leave everything unchanged
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = '1;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic                   req_tuser = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_IDX_W-1:0]   csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   // Per-cent chance of a sender idle cycle / of a receiver stall cycle
   int tx_idle_pct = 17;
   int rx_idle_pct = 47;
   int stall_cycles = 0;

   admission_scoreboard sb = new();

   task_admission_controller_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Receiver back-pressure, redrawn every cycle
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rx_idle_pct);
   end

   // Monitor: everything is sampled at the edge, i.e. the values the DUT saw.
   // Register writes go into the scoreboard copy as they are taken, requests are
   // decided in acceptance order, responses are checked in arrival order.
   always @(posedge clock) begin : monitor
      request_type rq;
      result_type  got;
      if (!reset) begin
         if (csr_valid && csr_ready) sb.write_reg(csr_index, csr_wdata);
         if (req_tvalid && req_tready) begin
            rq      = '0;
            rq.kind = req_kind_type'(req_tuser);
            {rq.was_accepted, rq.sched_time_ns, rq.evt_time_ns, rq.node_deadline_ns,
             rq.resource_mask, rq.exclusive_lock, rq.par_allowed, rq.parallel_group,
             rq.cap_group, rq.ports_ready, rq.deps_ready} = req_tdata[200:0];
            sb.note_request(rq);
         end
         if (rsp_tvalid && rsp_tready) begin
            got.accepted          = rsp_tdata[0];
            got.status_code       = status_type'(rsp_tdata[2:1]);
            got.reason_code       = reason_type'(rsp_tdata[6:3]);
            got.blocked_resources = rsp_tdata[22:7];
            got.deadline_state    = dl_state_type'(rsp_tdata[24:23]);
            got.late_ns           = rsp_tdata[87:25];
            got.active_tasks      = rsp_tdata[95:88];
            sb.check_verdict(got);
         end
      end
   end

   // Watchdog: counts cycles in which no transaction happens on any channel
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
         stall_cycles = 0;
      else
         stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Admit request with every field given
   function automatic request_type admit_item(logic deps, logic ports, logic [CG_W-1:0] cg,
                                              logic [PG_W-1:0] pg, logic par, logic excl,
                                              logic [RES_W-1:0] mask, logic [DL_W-1:0] dl,
                                              logic [TIME_W-1:0] ev, logic [TIME_W-1:0] sch);
      request_type rq;
      rq                   = '0;
      rq.kind              = REQ_ADMIT;
      rq.deps_ready        = deps;
      rq.ports_ready       = ports;
      rq.cap_group         = cg;
      rq.parallel_group    = pg;
      rq.par_allowed       = par;
      rq.exclusive_lock    = excl;
      rq.resource_mask     = mask;
      rq.node_deadline_ns  = dl;
      rq.evt_time_ns       = ev;
      rq.sched_time_ns     = sch;
      return rq;
   endfunction

   // Admit request with random content; readiness mostly present, masks mostly
   // sparse so that lock conflicts come and go, lateness mostly near the deadlines
   function automatic request_type random_admit();
      request_type rq;
      rq                  = '0;
      rq.kind             = REQ_ADMIT;
      rq.deps_ready       = ($urandom_range(9) != 0);
      rq.ports_ready      = ($urandom_range(9) != 0);
      rq.cap_group        = CG_W'($urandom_range(3));
      rq.parallel_group   = ($urandom_range(7) != 0) ? PG_W'($urandom_range(NUM_PAR_GROUPS))
                                                      : PG_W'($urandom_range(15));
      rq.par_allowed      = ($urandom_range(9) < 7);
      rq.exclusive_lock   = ($urandom_range(9) < 3);
      rq.was_accepted     = 1'($urandom_range(1));
      case ($urandom_range(7))
         0: rq.resource_mask = '0;
         1: rq.resource_mask = RES_W'($urandom);
         2: rq.resource_mask = '1;
         default: begin
            rq.resource_mask = RES_W'(1) << $urandom_range(RES_W - 1);
            if ($urandom_range(1)) rq.resource_mask[$urandom_range(RES_W - 1)] = 1'b1;
         end
      endcase
      case ($urandom_range(4))
         0, 1: rq.node_deadline_ns = '0;
         2, 3: rq.node_deadline_ns = DL_W'($urandom_range(1, 3000));
         default: rq.node_deadline_ns = DL_W'({$urandom, $urandom});
      endcase
      if ($urandom_range(3) == 0) begin
         rq.evt_time_ns   = TIME_W'({$urandom, $urandom});
         rq.sched_time_ns = TIME_W'({$urandom, $urandom});
      end else begin
         rq.sched_time_ns = TIME_W'({$urandom, $urandom}) >> $urandom_range(TIME_W - 1);
         rq.evt_time_ns   = rq.sched_time_ns + TIME_W'($urandom_range(3000))
                            - TIME_W'($urandom_range(500));
      end
      return rq;
   endfunction

   // Completion of a task; the unused fields carry random content
   function automatic request_type retire_item(logic [CG_W-1:0] cg, logic [PG_W-1:0] pg,
                                               logic [RES_W-1:0] mask, logic was_acc);
      request_type rq;
      rq                = random_admit();
      rq.kind           = REQ_COMPLETE;
      rq.cap_group      = cg;
      rq.parallel_group = pg;
      rq.resource_mask  = mask;
      rq.was_accepted   = was_acc;
      return rq;
   endfunction

   // One request transaction. Before it, idle cycles are drawn one at a time;
   // valid stays high from one transaction to the next when none is drawn.
   task automatic send_request(request_type rq);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tuser  <= rq.kind;
      req_tdata  <= {7'd0, rq.was_accepted, rq.sched_time_ns, rq.evt_time_ns,
                     rq.node_deadline_ns, rq.resource_mask, rq.exclusive_lock,
                     rq.par_allowed, rq.parallel_group, rq.cap_group,
                     rq.ports_ready, rq.deps_ready};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
   endtask

   // Wait until every response is in, then let the pipeline settle
   task automatic wait_for_quiet();
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // One register write; valid is left high for back-to-back writes
   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_index <= idx;
      csr_wdata <= data;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
   endtask

   // Write every register once the block has gone idle. Unused upper data bits
   // are random, and a write to the spare index follows.
   task automatic program_registers(cfg_type c);
      logic [CSR_DATA_W-1:0] word;
      req_tvalid <= 1'b0;
      wait_for_quiet();
      word = CSR_DATA_W'({$urandom, $urandom});
      word[CNT_W-1:0] = c.max_parallel;
      write_csr(CSR_MAX_PARALLEL, word);
      write_csr(CSR_DEFAULT_DEADLINE, c.default_deadline_ns);
      word = CSR_DATA_W'({$urandom, $urandom});
      word[0] = c.stale_on_miss;
      write_csr(CSR_STALE_ON_MISS, word);
      for (int g = 0; g < NUM_CAP_GROUPS; g++) begin
         word = CSR_DATA_W'({$urandom, $urandom});
         word[CNT_W-1:0] = c.group_limit[g];
         write_csr(CSR_IDX_W'(CSR_GROUP_LIMIT_0 + g), word);
      end
      write_csr(CSR_SPARE, CSR_DATA_W'({$urandom, $urandom}));
      csr_valid <= 1'b0;
   endtask

   // New register settings, weighted towards the extremes
   task automatic shuffle_registers();
      cfg_type c;
      c = '0;
      case ($urandom_range(5))
         0: c.max_parallel = 8'd0;
         1: c.max_parallel = 8'd1;
         2: c.max_parallel = 8'd2;
         3: c.max_parallel = CNT_MAX;
         default: c.max_parallel = CNT_W'($urandom_range(3, 12));
      endcase
      case ($urandom_range(3))
         0: c.default_deadline_ns = '0;
         1: c.default_deadline_ns = DL_W'($urandom_range(1, 3000));
         2: c.default_deadline_ns = '1;
         default: c.default_deadline_ns = DL_W'({$urandom, $urandom});
      endcase
      c.stale_on_miss = 1'($urandom_range(1));
      for (int g = 0; g < NUM_CAP_GROUPS; g++) begin
         case ($urandom_range(4))
            0: c.group_limit[g] = 8'd0;
            1: c.group_limit[g] = 8'd1;
            2: c.group_limit[g] = 8'd2;
            3: c.group_limit[g] = CNT_MAX;
            default: c.group_limit[g] = CNT_W'($urandom_range(3, 8));
         endcase
      end
      program_registers(c);
   endtask

   // Mostly admit/complete pairs: a completion usually retires a task the block
   // accepted, with its own group and mask. The rest are stray completions.
   task automatic run_random(int n);
      request_type rq;
      request_type held;
      int          roll;
      int          pick;
      repeat (n) begin
         roll = $urandom_range(99);
         if (sb.running_tasks.size() != 0 && roll < 45) begin
            pick = $urandom_range(sb.running_tasks.size() - 1);
            held = sb.running_tasks[pick];
            sb.running_tasks.delete(pick);
            rq = retire_item(held.cap_group, held.parallel_group, held.resource_mask,
                             $urandom_range(9) != 0);
         end else if (roll < 55) begin
            rq      = random_admit();
            rq.kind = REQ_COMPLETE;
         end else begin
            rq = random_admit();
         end
         send_request(rq);
      end
   endtask

   // Drive both counters into saturation at the top and then back through zero
   task automatic flood_counters();
      cfg_type c;
      c = '0;   // no global or group limit, no default deadline, misses blocked
      program_registers(c);
      repeat (280) send_request(admit_item(1, 1, 0, PG_W'($urandom_range(NUM_PAR_GROUPS)), 1, 0,
                                           '0, '0, '0, '0));
      repeat (280) send_request(retire_item(0, 0, '0, 1));
      sb.running_tasks.delete();
   endtask

   initial begin : stimulus
      cfg_type c;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part, first under the reset settings: one task at a time,
      // no default deadline, a miss marks the task stale.
      send_request(admit_item(0, 1, 0, 0, 1, 0, 16'hFFFF, '0, 63'd500, 63'd100)); // deps
      send_request(admit_item(1, 0, 0, 0, 1, 0, 16'h0000, '0, '0, '0));           // ports
      send_request(admit_item(1, 1, 1, 1, 1, 0, 16'h0003, '0, '0, '0));           // taken
      send_request(admit_item(1, 1, 0, 0, 1, 0, 16'h0000, '0, '0, '0));           // maxpar
      // exclusive request over a shared lock conflicts; shared over shared does not
      send_request(admit_item(1, 1, 0, 0, 1, 1, 16'h0002, '0, '0, '0));
      send_request(admit_item(1, 1, 0, 0, 1, 0, 16'h0001, '0, '0, '0));
      send_request(retire_item(1, 1, 16'h0003, 0));   // never accepted: no effect
      send_request(retire_item(1, 1, 16'h0001, 1));   // bit 1 stays locked
      send_request(retire_item(3, 15, 16'h0000, 1));  // count floors at zero, group 15 = none
      send_request(admit_item(1, 1, 0, 0, 0, 1, 16'h8002, '0, '0, '0));           // locked
      send_request(retire_item(1, 0, 16'hFFFF, 1));   // clears every lock
      send_request(admit_item(1, 1, 2, 8, 0, 1, 16'h8000, '0, '0, '1));           // early
      send_request(admit_item(1, 1, 0, 0, 1, 0, 16'h8000, '0, '0, '0));           // excl held

      // Unlimited globally, group 0 limited to one, default deadline, misses blocked
      c = '0;
      c.default_deadline_ns = 48'd1000;
      c.group_limit[0]      = 8'd1;
      c.group_limit[3]      = CNT_MAX;
      program_registers(c);
      send_request(admit_item(1, 1, 0, 0, 1, 0, '0, '0, 63'd1500, 63'd1000));     // within
      send_request(admit_item(1, 1, 0, 0, 1, 0, '0, '0, '0, '0));                 // capacity
      send_request(admit_item(1, 1, 1, 0, 0, 0, '0, '0, '0, '0));                 // exclusive
      send_request(admit_item(1, 1, 1, 3, 1, 0, '0, '0, 63'd1000, '0));           // late = dl
      // retire everything, but leave parallel group 3 marked busy
      send_request(retire_item(1, 0, '0, 1));
      send_request(retire_item(0, 0, '0, 1));
      send_request(retire_item(2, 8, 16'h8000, 1));
      send_request(admit_item(1, 1, 1, 3, 0, 0, '0, '0, '0, '0));                 // pargroup
      send_request(admit_item(1, 1, 3, 0, 1, 0, '0, '0, 63'd1001, '0));           // missed
      send_request(admit_item(1, 1, 3, 0, 1, 1, '1, '1, '1, '0));                 // extremes

      // Top of every range, misses stale
      c.max_parallel        = CNT_MAX;
      c.default_deadline_ns = '1;
      c.stale_on_miss       = 1'b1;
      for (int g = 0; g < NUM_CAP_GROUPS; g++) c.group_limit[g] = CNT_MAX;
      program_registers(c);
      send_request(admit_item(1, 1, 2, 0, 1, 0, '0, '0, '1, '0));                 // stale
      send_request(admit_item(1, 1, 2, 0, 1, 0, '0, '0, 63'd10, '0));             // taken

      flood_counters();
      repeat (3) begin
         shuffle_registers();
         run_random(130);
      end

      // Receiver now mostly ready, sender gaps more frequent
      tx_idle_pct = 47;
      rx_idle_pct = 17;
      repeat (4) begin
         shuffle_registers();
         run_random(130);
      end

      // Full rate in both directions
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      repeat (3) begin
         shuffle_registers();
         run_random(130);
      end

      req_tvalid <= 1'b0;
      wait_for_quiet();
      if (sb.failures() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
